// ===== rtl/polar_gaussian_transform_defines.svh =====
// assertion macros for the polar gaussian transform
// depends on nothing; taken in by the files that assert
`ifndef POLAR_GAUSSIAN_TRANSFORM_DEFINES_SVH
`define POLAR_GAUSSIAN_TRANSFORM_DEFINES_SVH
`ifndef ASSERT_OFF
`define PGT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pgt implication check failed");
`define PGT_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("pgt forbidden condition seen");
`else
`define PGT_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define PGT_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== rtl/pgt_pkg.sv =====
// shared types and constants of the polar gaussian transform
// depends on nothing
package pgt_pkg;

   typedef struct packed {
      logic valid;
      logic negative;
   } pgt_side_type;

   // width of u1^2 and of s, both below 2^30 once accepted
   localparam int SQ_W = 30;

   // ln 2 with 32 fraction bits
   localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

   localparam int CSR_INDEX_W = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MEAN_VALUE    = 8'd0,
      CSR_STD_DEVIATION = 8'd1
   } pgt_csr_index_type;

endpackage

// ===== rtl/pgt_log2.sv =====
// pipelined -log2 of s in q.FRAC_BITS: normalise, then one squaring stage per bit
// depends on pgt_pkg
module pgt_log2 #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pgt_pkg::pgt_side_type     side_in,
   input  logic [pgt_pkg::SQ_W-1:0]  s_in,
   input  logic [pgt_pkg::SQ_W-1:0]  u_in,
   output pgt_pkg::pgt_side_type     side_out,
   output logic [pgt_pkg::SQ_W-1:0]  s_out,
   output logic [pgt_pkg::SQ_W-1:0]  u_out,
   output logic [FRAC_BITS+4:0]      nlog_out
);
   import pgt_pkg::*;

   localparam int NW = FRAC_BITS + 5;

   pgt_side_type          side_ff [0:FRAC_BITS];
   pgt_side_type          side_in_a [0:FRAC_BITS];
   logic [SQ_W-1:0]       s_ff    [0:FRAC_BITS];
   logic [SQ_W-1:0]       u_ff    [0:FRAC_BITS];
   logic [4:0]            e_ff    [0:FRAC_BITS];
   logic [30:0]           x_ff    [0:FRAC_BITS];
   logic [30:0]           x_in    [0:FRAC_BITS];
   logic [FRAC_BITS-1:0]  g_ff    [0:FRAC_BITS];
   logic [FRAC_BITS-1:0]  g_in    [0:FRAC_BITS];
   logic [61:0]           sq_w    [0:FRAC_BITS-1];
   logic [31:0]           y_w     [0:FRAC_BITS-1];
   logic [4:0]            e_norm;
   pgt_side_type          side_n_ff;
   logic [SQ_W-1:0]       s_n_ff;
   logic [SQ_W-1:0]       u_n_ff;
   logic [NW-1:0]         n_ff;
   logic [NW-1:0]         n_in;

   // shift that brings the top set bit to bit 30
   always_comb begin
      e_norm = 5'd30;
      for (int i = 0; i < SQ_W; i++) begin
         if (s_in[i]) begin
            e_norm = 5'(30 - i);
         end
      end
   end

   always_comb begin
      side_in_a[0] = side_in;
      x_in[0] = 31'({1'b0, s_in} << e_norm);
      g_in[0] = '0;
      for (int k = 0; k < FRAC_BITS; k++) begin
         side_in_a[k+1] = side_ff[k];
         sq_w[k] = 62'(x_ff[k]) * 62'(x_ff[k]);
         y_w[k] = sq_w[k][61:30];
         x_in[k+1] = y_w[k][31] ? y_w[k][31:1] : y_w[k][30:0];
         g_in[k+1] = {g_ff[k][FRAC_BITS-2:0], y_w[k][31]};
      end
      n_in = {e_ff[FRAC_BITS], {FRAC_BITS{1'b0}}} - {5'b0, g_ff[FRAC_BITS]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= FRAC_BITS; k++) begin
            side_ff[k] <= '0;
         end
         side_n_ff <= '0;
      end else begin
         for (int k = 0; k <= FRAC_BITS; k++) begin
            side_ff[k] <= side_in_a[k];
         end
         side_n_ff <= side_ff[FRAC_BITS];
      end
      s_ff[0] <= s_in;
      u_ff[0] <= u_in;
      e_ff[0] <= e_norm;
      for (int k = 0; k < FRAC_BITS; k++) begin
         s_ff[k+1] <= s_ff[k];
         u_ff[k+1] <= u_ff[k];
         e_ff[k+1] <= e_ff[k];
      end
      for (int k = 0; k <= FRAC_BITS; k++) begin
         x_ff[k] <= x_in[k];
         g_ff[k] <= g_in[k];
      end
      s_n_ff <= s_ff[FRAC_BITS];
      u_n_ff <= u_ff[FRAC_BITS];
      n_ff   <= n_in;
   end

   assign side_out = side_n_ff;
   assign s_out    = s_n_ff;
   assign u_out    = u_n_ff;
   assign nlog_out = n_ff;

endmodule

// ===== rtl/pgt_root.sv =====
// pipelined floor(l*u/s) by one quotient bit a stage, then floor square root
// depends on pgt_pkg
module pgt_root #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pgt_pkg::pgt_side_type     side_in,
   input  logic [FRAC_BITS+5:0]      l_in,
   input  logic [pgt_pkg::SQ_W-1:0]  u_in,
   input  logic [pgt_pkg::SQ_W-1:0]  s_in,
   output pgt_pkg::pgt_side_type     side_out,
   output logic [FRAC_BITS+2:0]      root_out
);
   import pgt_pkg::*;

   localparam int LW  = FRAC_BITS + 6;
   localparam int PW  = LW + SQ_W;
   localparam int VW  = LW + FRAC_BITS;
   localparam int RW  = VW / 2;
   localparam int RMW = RW + 2;
   localparam int TW  = RW + 4;

   pgt_side_type     dv_side_ff [0:LW];
   logic [SQ_W-1:0]  dv_s_ff    [0:LW];
   logic [PW-1:0]    dv_w_ff    [0:LW];
   logic [PW-1:0]    dv_w_in    [1:LW];
   logic [SQ_W:0]    dv_t       [0:LW-1];
   logic [SQ_W:0]    dv_d       [0:LW-1];
   logic [VW-1:0]    v_first;
   pgt_side_type     sq_side_ff [0:RW-1];
   logic [RMW-1:0]   sq_rem_ff  [0:RW-1];
   logic [RW-1:0]    sq_root_ff [0:RW-1];
   logic [VW-1:0]    sq_v_ff    [0:RW-1];
   logic [RMW+RW-1:0] sq_step   [0:RW-1];

   function automatic logic [RMW+RW-1:0] root_step(input logic [RMW-1:0] rem,
                                                   input logic [RW-1:0] root,
                                                   input logic [1:0] two);
      logic [TW-1:0] t;
      logic [TW-1:0] trial;
      t = {rem, two};
      trial = {2'b00, root, 2'b01};
      if (t >= trial) begin
         root_step = {RMW'(t - trial), root[RW-2:0], 1'b1};
      end else begin
         root_step = {RMW'(t), root[RW-2:0], 1'b0};
      end
   endfunction

   // remainder in the top bits, quotient shifts in at the bottom
   always_comb begin
      for (int k = 0; k < LW; k++) begin
         dv_t[k] = dv_w_ff[k][PW-1:LW-1];
         dv_d[k] = dv_t[k] - {1'b0, dv_s_ff[k]};
         if (dv_t[k] >= {1'b0, dv_s_ff[k]}) begin
            dv_w_in[k+1] = {dv_d[k][SQ_W-1:0], dv_w_ff[k][LW-2:0], 1'b1};
         end else begin
            dv_w_in[k+1] = {dv_t[k][SQ_W-1:0], dv_w_ff[k][LW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      v_first = {dv_w_ff[LW][LW-1:0], {FRAC_BITS{1'b0}}};
      sq_step[0] = root_step('0, '0, v_first[VW-1:VW-2]);
      for (int k = 1; k < RW; k++) begin
         sq_step[k] = root_step(sq_rem_ff[k-1], sq_root_ff[k-1],
                                sq_v_ff[k-1][VW-1:VW-2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LW; k++) begin
            dv_side_ff[k] <= '0;
         end
         for (int k = 0; k < RW; k++) begin
            sq_side_ff[k] <= '0;
         end
      end else begin
         dv_side_ff[0] <= side_in;
         for (int k = 0; k < LW; k++) begin
            dv_side_ff[k+1] <= dv_side_ff[k];
         end
         sq_side_ff[0] <= dv_side_ff[LW];
         for (int k = 1; k < RW; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
      dv_w_ff[0] <= PW'(l_in) * PW'(u_in);
      dv_s_ff[0] <= s_in;
      for (int k = 0; k < LW; k++) begin
         dv_w_ff[k+1] <= dv_w_in[k+1];
         dv_s_ff[k+1] <= dv_s_ff[k];
      end
      sq_rem_ff[0]  <= sq_step[0][RMW+RW-1:RW];
      sq_root_ff[0] <= sq_step[0][RW-1:0];
      sq_v_ff[0]    <= v_first << 2;
      for (int k = 1; k < RW; k++) begin
         sq_rem_ff[k]  <= sq_step[k][RMW+RW-1:RW];
         sq_root_ff[k] <= sq_step[k][RW-1:0];
         sq_v_ff[k]    <= sq_v_ff[k-1] << 2;
      end
   end

   assign side_out = sq_side_ff[RW-1];
   assign root_out = sq_root_ff[RW-1];

endmodule

// ===== rtl/polar_gaussian_transform.sv =====
// polar gaussian transform top level, built from pgt_log2 and pgt_root; uses pgt_pkg
// one word taken every cycle
// depth set by one squaring stage per log bit and one stage per quotient and root bit
// busy never rises and the receiver cannot stall, so the pipeline always advances
// synchronous reset clears the valid bits and sets mean 0 and deviation 1.0
`include "polar_gaussian_transform_defines.svh"
module polar_gaussian_transform #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   output logic                                busy,
   input  logic signed [15:0]                  req_uniform_a,
   input  logic signed [15:0]                  req_uniform_b,
   output logic                                rsp_strobe,
   output logic signed [31:0]                  rsp_normal_sample,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pgt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_wdata
);
   import pgt_pkg::*;

   localparam int NW  = FRAC_BITS + 5;          // -log2 s
   localparam int LW  = FRAC_BITS + 6;          // -2 ln s
   localparam int RW  = (LW + FRAC_BITS) / 2;   // square root
   localparam int PRW = 31 + RW;                // deviation times root
   localparam int MW  = PRW + 1 - FRAC_BITS;    // rounded magnitude
   localparam int XW  = MW + 2;                 // signed sum
   localparam int LPW = NW + 33;
   localparam int LATENCY = 1 + (FRAC_BITS + 2) + 1 + (1 + LW + RW) + 2;
   localparam logic signed [XW-1:0] SAMPLE_MAX = XW'(64'sh7FFF_FFFF);
   localparam logic signed [XW-1:0] SAMPLE_MIN = XW'(-64'sh8000_0000);

   // configuration registers
   logic signed [31:0]  mean_ff;
   logic [30:0]         std_ff;

   // stage 1: squares and radius test
   logic                start_accept;
   logic [15:0]         mag_a;
   logic [15:0]         mag_b;
   logic [31:0]         sq_a;
   logic [31:0]         s_sum;
   pgt_side_type        s1_side_in;
   pgt_side_type        s1_side_ff;
   logic [SQ_W-1:0]     s1_u_ff;
   logic [SQ_W-1:0]     s1_s_ff;

   // log output and ln stage
   pgt_side_type        lg_side;
   logic [SQ_W-1:0]     lg_s;
   logic [SQ_W-1:0]     lg_u;
   logic [NW-1:0]       lg_n;
   logic [LPW-1:0]      l_prod;
   pgt_side_type        ln_side_ff;
   logic [LW-1:0]       ln_l_ff;
   logic [SQ_W-1:0]     ln_u_ff;
   logic [SQ_W-1:0]     ln_s_ff;

   // root output, scaling and output stage
   pgt_side_type        rt_side;
   logic [RW-1:0]       rt_root;
   pgt_side_type        sc_side_ff;
   logic [PRW-1:0]      sc_prod_ff;
   logic [PRW:0]        rnd_sum;
   logic [MW-1:0]       mag;
   logic signed [XW-1:0] mag_x;
   logic signed [XW-1:0] mean_x;
   logic signed [XW-1:0] sum_x;
   logic signed [31:0]  sample_in;
   logic                sat_in;
   logic                rsp_strobe_ff;
   logic signed [31:0]  rsp_sample_ff;
   logic                rsp_sat_ff;

   // nothing ever holds the input off
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign start_accept = req_start && !busy;

   // register writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= '0;
         std_ff  <= 31'd65536;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MEAN_VALUE:    mean_ff <= csr_wdata;
            CSR_STD_DEVIATION: std_ff  <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // magnitudes, squares and rejection of zero radius or radius one or more
   always_comb begin
      mag_a = req_uniform_a[15] ? 16'(-req_uniform_a) : 16'(req_uniform_a);
      mag_b = req_uniform_b[15] ? 16'(-req_uniform_b) : 16'(req_uniform_b);
      sq_a  = 32'(mag_a) * 32'(mag_a);
      s_sum = sq_a + 32'(mag_b) * 32'(mag_b);
      s1_side_in.valid    = start_accept && (s_sum != '0) && (s_sum[31:30] == 2'b00);
      s1_side_in.negative = req_uniform_a[15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff <= '0;
      end else begin
         s1_side_ff <= s1_side_in;
      end
      s1_u_ff <= sq_a[SQ_W-1:0];
      s1_s_ff <= s_sum[SQ_W-1:0];
   end

   pgt_log2 #(
      .FRAC_BITS (FRAC_BITS)
   ) u_log2 (
      .clock    (clock),
      .reset    (reset),
      .side_in  (s1_side_ff),
      .s_in     (s1_s_ff),
      .u_in     (s1_u_ff),
      .side_out (lg_side),
      .s_out    (lg_s),
      .u_out    (lg_u),
      .nlog_out (lg_n)
   );

   // -2 ln s = round(n * 2 ln 2), rounding folded into one add
   assign l_prod = LPW'(lg_n) * LPW'(LN2_Q32) + (LPW'(1) << 30);

   always_ff @(posedge clock) begin
      if (reset) begin
         ln_side_ff <= '0;
      end else begin
         ln_side_ff <= lg_side;
      end
      ln_l_ff <= l_prod[31+LW-1:31];
      ln_u_ff <= lg_u;
      ln_s_ff <= lg_s;
   end

   pgt_root #(
      .FRAC_BITS (FRAC_BITS)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .side_in  (ln_side_ff),
      .l_in     (ln_l_ff),
      .u_in     (ln_u_ff),
      .s_in     (ln_s_ff),
      .side_out (rt_side),
      .root_out (rt_root)
   );

   // scale by the deviation
   always_ff @(posedge clock) begin
      if (reset) begin
         sc_side_ff <= '0;
      end else begin
         sc_side_ff <= rt_side;
      end
      sc_prod_ff <= PRW'(std_ff) * PRW'(rt_root);
   end

   // round, apply the sign of u1, add the mean and clip
   always_comb begin
      rnd_sum = (PRW+1)'(sc_prod_ff) + ((PRW+1)'(1) << (FRAC_BITS - 1));
      mag     = rnd_sum[PRW:FRAC_BITS];
      mag_x   = $signed(XW'(mag));
      mean_x  = XW'(mean_ff);
      sum_x   = sc_side_ff.negative ? (mean_x - mag_x) : (mean_x + mag_x);
      if (sum_x > SAMPLE_MAX) begin
         sample_in = 32'sh7FFF_FFFF;
         sat_in    = 1'b1;
      end else if (sum_x < SAMPLE_MIN) begin
         sample_in = -32'sh8000_0000;
         sat_in    = 1'b1;
      end else begin
         sample_in = sum_x[31:0];
         sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= sc_side_ff.valid;
      end
      rsp_sample_ff <= sample_in;
      rsp_sat_ff    <= sat_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_normal_sample = rsp_sample_ff;
   assign rsp_saturated     = rsp_sat_ff;

   // every result word goes back to a word taken at the input
   `PGT_ASSERT_IMPLY(a_result_has_source, clock, reset, rsp_strobe, $past(start_accept, LATENCY))
   // a zero pair never yields a word
   `PGT_ASSERT_IMPLY(a_zero_dropped, clock, reset, $past(start_accept && req_uniform_a == 16'sd0 && req_uniform_b == 16'sd0, LATENCY), !rsp_strobe)
   // clipping only ever lands on the two range ends
   `PGT_ASSERT_NEVER(a_sat_at_ends, clock, reset, rsp_strobe && rsp_saturated && rsp_normal_sample != 32'sh7FFF_FFFF && rsp_normal_sample != -32'sh8000_0000)

endmodule

// ===== test/polar_gaussian_transform_tb.sv =====
// self-checking testbench for the polar gaussian transform: directed and random uniform pairs
// depends on pgt_pkg and the polar_gaussian_transform top level; predicts each sample in a class
class pgt_sample_board;
   logic signed [31:0] mean_q;
   logic [30:0]        dev_q;
   logic [32:0]        pending[$];
   int                 mismatches;
   int                 checked;

   function new();
      mean_q = 0;
      dev_q = 31'd65536;
      mismatches = 0;
      checked = 0;
   endfunction

   // -log2(s) with 16 fraction bits, s = sv / 2^30
   function automatic longint unsigned neg_log2(longint unsigned sv);
      int p;
      longint unsigned x, g;
      p = 29;
      g = 0;
      while (p > 0 && sv[p] == 1'b0) p--;
      x = sv << (30 - p);
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> 30;
         g = g << 1;
         if (x >= 64'h8000_0000) begin
            x = x >> 1;
            g = g | 1;
         end
      end
      return (longint'(30 - p) << 16) - g;
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // notes an accepted pair; rejected pairs leave nothing pending
   function void note_pair(logic signed [15:0] ua, logic signed [15:0] ub);
      longint a1, a2;
      longint unsigned uu, sv, nl, lv, tv, rv, mag;
      longint res;
      logic sat;
      a1 = ua < 0 ? -longint'(ua) : longint'(ua);
      a2 = ub < 0 ? -longint'(ub) : longint'(ub);
      uu = a1 * a1;
      sv = uu + a2 * a2;
      if (sv == 0 || sv >= 64'h4000_0000) return;
      nl = neg_log2(sv);
      lv = (nl * 2 * 64'hB172_17F8 + 64'h8000_0000) >> 32;
      tv = (lv * uu) / sv;
      rv = int_root(tv << 16);
      mag = (longint'(dev_q) * rv + 64'h8000) >> 16;
      res = longint'(mean_q) + (ua < 0 ? -longint'(mag) : longint'(mag));
      sat = 1'b0;
      if (res > 64'sd2147483647) begin
         res = 64'sd2147483647;
         sat = 1'b1;
      end else if (res < -64'sd2147483648) begin
         res = -64'sd2147483648;
         sat = 1'b1;
      end
      pending.push_back({sat, res[31:0]});
   endfunction

   function void check_sample(logic [31:0] sample, logic sat);
      logic [32:0] want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected sample %0d sat %0b", $signed(sample), sat);
         return;
      end
      want = pending.pop_front();
      checked++;
      if (want != {sat, sample}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("sample mismatch: expected %0d sat %0b, got %0d sat %0b",
                     $signed(want[31:0]), want[32], $signed(sample), sat);
      end
   endfunction
endclass

module polar_gaussian_transform_tb;
   import pgt_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_start = 1'b0;
   logic               busy;
   logic signed [15:0] req_uniform_a = '0;
   logic signed [15:0] req_uniform_b = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_normal_sample;
   logic               rsp_saturated;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   localparam int LATENCY = 64;
   localparam longint CYCLE_LIMIT = 400000;

   pgt_sample_board board = new();
   longint cycles = 0;
   int     pairs_sent = 0;

   polar_gaussian_transform DUT (.*);

   always #5 clock = ~clock;

   // results sampled on the rising edge; the receiver never stalls
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) board.check_sample(rsp_normal_sample, rsp_saturated);
      if (cycles >= CYCLE_LIMIT) begin
         $display("run timed out after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one, often none
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one word on the request side; start stays high across back-to-back pairs
   task automatic send_pair(logic signed [15:0] ua, logic signed [15:0] ub);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_start <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_start <= 1'b1;
      req_uniform_a <= ua;
      req_uniform_b <= ub;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_pair(ua, ub);
      pairs_sent++;
      @(negedge clock);
   endtask

   // wait out the pipeline so register writes land while idle
   task automatic drain();
      req_start <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   // valid drops for one cycle so back-to-back writes never collide
   task automatic write_reg(pgt_csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_MEAN_VALUE) board.mean_q = value;
      else board.dev_q = value[30:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // a random pair, mostly inside the unit circle so results come through
   task automatic random_pair();
      logic signed [15:0] ua, ub;
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) begin
         ua = $urandom_range(0, 46340) - 23170;
         ub = $urandom_range(0, 46340) - 23170;
      end else if (r < 8) begin
         ua = $urandom;
         ub = $urandom_range(0, 15) - 8;
      end else begin
         ua = $urandom;
         ub = $urandom;
      end
      send_pair(ua, ub);
   endtask

   initial begin
      logic [31:0] means[4];
      logic [31:0] devs[4];
      means = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFE_8000};
      devs  = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 32'h0003_2000};

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero radius, radius at or past one, zero first sample, extremes
      send_pair(16'sd0, 16'sd0);
      send_pair(-16'sd32768, 16'sd0);
      send_pair(16'sd0, -16'sd32768);
      send_pair(16'sd0, 16'sd1);
      send_pair(16'sd1, 16'sd0);
      send_pair(-16'sd1, 16'sd0);
      send_pair(16'sd32767, 16'sd0);
      send_pair(16'sd23170, 16'sd23170);
      send_pair(16'sd23170, 16'sd23169);
      send_pair(-16'sd23170, -16'sd23169);
      send_pair(16'sd1, 16'sd1);
      send_pair(16'sd32767, 16'sd32767);
      send_pair(16'sh5555, -16'sh2AAA);
      drain();

      // saturation both ways with wide deviation and extreme means
      write_reg(CSR_STD_DEVIATION, 32'hFFFF_FFFF);
      write_reg(CSR_MEAN_VALUE, 32'h7FFF_0000);
      send_pair(16'sd100, 16'sd0);
      send_pair(16'sd0, 16'sd5);
      drain();
      write_reg(CSR_MEAN_VALUE, 32'h8000_0000);
      send_pair(-16'sd100, 16'sd0);
      send_pair(16'sd100, 16'sd3);
      drain();

      // random phases over several register settings, extremes among them
      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            write_reg(CSR_MEAN_VALUE, ph < 4 ? means[ph] : $urandom);
            write_reg(CSR_STD_DEVIATION, ph < 4 ? devs[ph] : $urandom);
         end
         repeat (365) random_pair();
         drain();
      end

      if (board.pending.size() != 0) begin
         board.mismatches++;
         $display("%0d expected samples never arrived", board.pending.size());
      end
      $display("sent %0d uniform pairs, checked %0d samples over 5 register settings",
               pairs_sent, board.checked);
      if (board.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("Verification failed");
      end
      $finish;
   end
endmodule
